[rtl/core/ycb_pkg.sv]
// Shared types, sizes and configuration codes for the Yee curl-B stencil.
`default_nettype none

package ycb_pkg;

    // Grid and table sizes.
    localparam int MAX_X     = 64;
    localparam int MAX_Y     = 64;
    localparam int MAX_Z     = 64;
    localparam int MATERIALS = 16;

    // Field widths.
    localparam int POS_W   = 7;
    localparam int FIELD_W = 32;
    localparam int RMU_W   = 20;
    localparam int COEF_W  = 17;
    localparam int MAT_W   = 4;
    localparam int W_W     = 36;
    localparam int XI_W    = $clog2(MAX_X);
    localparam int YI_W    = $clog2(MAX_Y);
    localparam int PI_W    = XI_W + YI_W;
    localparam int TBL_W   = $clog2(MATERIALS);
    localparam int CFG_A_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_A_W-1:0] {
        CFG_COEF_X = 3'd0,
        CFG_COEF_Y = 3'd1,
        CFG_COEF_Z = 3'd2,
        CFG_SIZE_X = 3'd3,
        CFG_SIZE_Y = 3'd4,
        CFG_SIZE_Z = 3'd5
    } t_cfg_idx;

    // Item mode codes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_VOXEL = 1'b1;

    // One weighted field triple, signed Q.16.
    typedef struct packed {
        logic signed [W_W-1:0] wx;
        logic signed [W_W-1:0] wy;
        logic signed [W_W-1:0] wz;
    } t_wtrip;

    // Input word.
    typedef struct packed {
        logic                      mode;
        logic signed [FIELD_W-1:0] field_x;
        logic signed [FIELD_W-1:0] field_y;
        logic signed [FIELD_W-1:0] field_z;
        logic [MAT_W-1:0]          material_x;
        logic [MAT_W-1:0]          material_y;
        logic [MAT_W-1:0]          material_z;
        logic [MAT_W-1:0]          load_index;
        logic [RMU_W-1:0]          load_rmu_x;
        logic [RMU_W-1:0]          load_rmu_y;
        logic [RMU_W-1:0]          load_rmu_z;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic signed [FIELD_W-1:0] curl_x;
        logic signed [FIELD_W-1:0] curl_y;
        logic signed [FIELD_W-1:0] curl_z;
        logic [POS_W-1:0]          cell_x;
        logic [POS_W-1:0]          cell_y;
        logic [POS_W-1:0]          cell_z;
        logic                      last;
    } t_out_word;

endpackage

`default_nettype wire

[rtl/core/ycb_mat_table.sv]
// Material tables and the weighting of one voxel's field components.
`default_nettype none

module ycb_mat_table import ycb_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_load_en,
    input  wire logic [MAT_W-1:0]          i_load_index,
    input  wire logic [RMU_W-1:0]          i_load_rmu_x,
    input  wire logic [RMU_W-1:0]          i_load_rmu_y,
    input  wire logic [RMU_W-1:0]          i_load_rmu_z,
    input  wire logic                      i_weigh_en,
    input  wire logic signed [FIELD_W-1:0] i_field_x,
    input  wire logic signed [FIELD_W-1:0] i_field_y,
    input  wire logic signed [FIELD_W-1:0] i_field_z,
    input  wire logic [MAT_W-1:0]          i_mat_x,
    input  wire logic [MAT_W-1:0]          i_mat_y,
    input  wire logic [MAT_W-1:0]          i_mat_z,
    output t_wtrip                         o_w
);

    logic [RMU_W-1:0] r_tbl_x [MATERIALS];
    logic [RMU_W-1:0] r_tbl_y [MATERIALS];
    logic [RMU_W-1:0] r_tbl_z [MATERIALS];
    logic [RMU_W-1:0] rmu_x, rmu_y, rmu_z;
    t_wtrip           r_w;

    // Round field*rmu to Q.16.
    function automatic logic signed [W_W-1:0] weigh(
        input logic signed [FIELD_W-1:0] f,
        input logic [RMU_W-1:0]          r
    );
        logic signed [FIELD_W+RMU_W:0] p;
        p = f * $signed({1'b0, r});
        p = p + (FIELD_W+RMU_W+1)'(32768);
        return p[W_W+15:16];
    endfunction

    // Table writes from load words; rows out of range are dropped.
    always_ff @(posedge i_clk) begin
        if (i_load_en && ({1'b0, i_load_index} < (MAT_W+1)'(MATERIALS))) begin
            r_tbl_x[i_load_index[TBL_W-1:0]] <= i_load_rmu_x;
            r_tbl_y[i_load_index[TBL_W-1:0]] <= i_load_rmu_y;
            r_tbl_z[i_load_index[TBL_W-1:0]] <= i_load_rmu_z;
        end
    end

    // Factor lookup; an index past the table weighs with zero.
    always_comb begin
        rmu_x = ({1'b0, i_mat_x} < (MAT_W+1)'(MATERIALS)) ? r_tbl_x[i_mat_x[TBL_W-1:0]] : '0;
        rmu_y = ({1'b0, i_mat_y} < (MAT_W+1)'(MATERIALS)) ? r_tbl_y[i_mat_y[TBL_W-1:0]] : '0;
        rmu_z = ({1'b0, i_mat_z} < (MAT_W+1)'(MATERIALS)) ? r_tbl_z[i_mat_z[TBL_W-1:0]] : '0;
    end

    // Weighted triple register.
    always_ff @(posedge i_clk) begin
        if (i_weigh_en) begin
            r_w.wx <= weigh(i_field_x, rmu_x);
            r_w.wy <= weigh(i_field_y, rmu_y);
            r_w.wz <= weigh(i_field_z, rmu_z);
        end
    end

    assign o_w = r_w;

endmodule

`default_nettype wire

[rtl/core/ycb_nbr_store.sv]
// Neighbor storage: previous voxel register, row memory and plane memory.
`default_nettype none

module ycb_nbr_store import ycb_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rd_en,
    input  wire logic            i_wr_en,
    input  wire logic [XI_W-1:0] i_x_idx,
    input  wire logic [YI_W-1:0] i_y_idx,
    input  wire t_wtrip          i_wr,
    output t_wtrip               o_prev,
    output t_wtrip               o_row,
    output t_wtrip               o_plane
);

    t_wtrip r_row_mem   [MAX_X];
    t_wtrip r_plane_mem [MAX_X*MAX_Y];
    t_wtrip r_row_rd;
    t_wtrip r_plane_rd;
    t_wtrip r_prev;
    logic [PI_W-1:0] plane_addr;

    assign plane_addr = {i_y_idx, i_x_idx};

    // Row memory, one read and one write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_row_mem[i_x_idx] <= i_wr;
        end
        if (i_rd_en) begin
            r_row_rd <= r_row_mem[i_x_idx];
        end
    end

    // Plane memory, one read and one write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_plane_mem[plane_addr] <= i_wr;
        end
        if (i_rd_en) begin
            r_plane_rd <= r_plane_mem[plane_addr];
        end
    end

    // Previous voxel along x.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_prev <= i_wr;
        end
    end

    assign o_prev  = r_prev;
    assign o_row   = r_row_rd;
    assign o_plane = r_plane_rd;

endmodule

`default_nettype wire

[rtl/core/ycb_curl.sv]
// Curl arithmetic: differences times coefficients, then round and saturate.
`default_nettype none

module ycb_curl import ycb_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [COEF_W-1:0]          i_coef_x,
    input  wire logic [COEF_W-1:0]          i_coef_y,
    input  wire logic [COEF_W-1:0]          i_coef_z,
    input  wire t_wtrip                     i_cur,
    input  wire t_wtrip                     i_nx,
    input  wire t_wtrip                     i_ny,
    input  wire t_wtrip                     i_nz,
    output logic signed [FIELD_W-1:0]       o_curl_x,
    output logic signed [FIELD_W-1:0]       o_curl_y,
    output logic signed [FIELD_W-1:0]       o_curl_z
);

    localparam int D_W = W_W + 1;
    localparam int P_W = D_W + COEF_W + 1;
    localparam int S_W = P_W + 1;
    localparam int V_W = S_W - 16;

    logic signed [P_W-1:0] r_p [6];

    function automatic logic signed [P_W-1:0] term(
        input logic [COEF_W-1:0]     c,
        input logic signed [W_W-1:0] a,
        input logic signed [W_W-1:0] b
    );
        logic signed [D_W-1:0] d;
        d = $signed({a[W_W-1], a}) - $signed({b[W_W-1], b});
        return $signed({1'b0, c}) * d;
    endfunction

    function automatic logic signed [FIELD_W-1:0] finish(
        input logic signed [P_W-1:0] a,
        input logic signed [P_W-1:0] b
    );
        logic signed [S_W-1:0] t;
        logic signed [V_W-1:0] v;
        t = $signed({a[P_W-1], a}) - $signed({b[P_W-1], b}) + S_W'(32768);
        v = t[S_W-1:16];
        if (v > $signed(V_W'(32'h7FFF_FFFF))) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -$signed(V_W'(33'h0_8000_0000))) begin
            return 32'sh8000_0000;
        end
        return v[FIELD_W-1:0];
    endfunction

    // Six products, registered.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= term(i_coef_y, i_cur.wz, i_ny.wz);
            r_p[1] <= term(i_coef_z, i_cur.wy, i_nz.wy);
            r_p[2] <= term(i_coef_z, i_cur.wx, i_nz.wx);
            r_p[3] <= term(i_coef_x, i_cur.wz, i_nx.wz);
            r_p[4] <= term(i_coef_x, i_cur.wy, i_nx.wy);
            r_p[5] <= term(i_coef_y, i_cur.wx, i_ny.wx);
        end
    end

    // Combine pairs, round and saturate.
    assign o_curl_x = finish(r_p[0], r_p[1]);
    assign o_curl_y = finish(r_p[2], r_p[3]);
    assign o_curl_z = finish(r_p[4], r_p[5]);

endmodule

`default_nettype wire

[rtl/core/yee_curl_b_stencil_top.sv]
// Top level of the Yee curl-B stencil: sequencer, position, config and output word.
// A voxel word is read and weighed, multiplied and finished in the weigh, diff and sum states;
// its result word is registered from the sum state, which waits while a held output word stalls.
// The input stalls until a voxel word is through the sum state; a load word does not stall it.
// Reset clears the sequencer, position (1,1,1), config registers and output valid.
// Tables and neighbor memories are not cleared; no clearing pass is run.
`default_nettype none

module yee_curl_b_stencil_top import ycb_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_A_W-1:0] i_cfg_addr,
    input  wire logic [COEF_W-1:0]  i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_word           i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_word               o_out_word
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WEIGH = 4'b0010,
        S_DIFF  = 4'b0100,
        S_SUM   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [COEF_W-1:0] r_coef_x, r_coef_y, r_coef_z;
    logic [POS_W-1:0]  r_size_x, r_size_y, r_size_z;
    logic [POS_W-1:0]  r_pos_x, r_pos_y, r_pos_z, n_pos_x, n_pos_y, n_pos_z;
    logic [POS_W-1:0]  r_cx, r_cy, r_cz;
    logic              r_emit, r_last;
    logic signed [FIELD_W-1:0] r_fx, r_fy, r_fz;
    logic [MAT_W-1:0]  r_mx, r_my, r_mz;
    t_out_word         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic in_acc, vox_acc, load_acc, out_load;
    logic [POS_W-1:0] sx, sy, sz, x, y, z, xm1, ym1;
    t_wtrip cur_w, nb_x, nb_y, nb_z;
    logic signed [FIELD_W-1:0] curl_x, curl_y, curl_z;

    function automatic logic [POS_W-1:0] clamp_size(
        input logic [POS_W-1:0] s,
        input logic [POS_W-1:0] m
    );
        if (s == '0) begin
            return POS_W'(1);
        end
        return (s > m) ? m : s;
    endfunction

    function automatic logic [POS_W-1:0] fix_pos(
        input logic [POS_W-1:0] p,
        input logic [POS_W-1:0] m
    );
        return (p == '0 || p > m) ? POS_W'(1) : p;
    endfunction

    assign in_acc     = i_in_valid && !o_in_stall;
    assign vox_acc    = in_acc && (i_in_word.mode == MODE_VOXEL);
    assign load_acc   = in_acc && (i_in_word.mode == MODE_LOAD);
    assign o_in_stall = (r_state != S_IDLE);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_x <= '0;
            r_coef_y <= '0;
            r_coef_z <= '0;
            r_size_x <= POS_W'(1);
            r_size_y <= POS_W'(1);
            r_size_z <= POS_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_COEF_X: r_coef_x <= i_cfg_data;
                CFG_COEF_Y: r_coef_y <= i_cfg_data;
                CFG_COEF_Z: r_coef_z <= i_cfg_data;
                CFG_SIZE_X: r_size_x <= i_cfg_data[POS_W-1:0];
                CFG_SIZE_Y: r_size_y <= i_cfg_data[POS_W-1:0];
                CFG_SIZE_Z: r_size_z <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Current coordinates and raster advance.
    always_comb begin
        sx = clamp_size(r_size_x, POS_W'(MAX_X));
        sy = clamp_size(r_size_y, POS_W'(MAX_Y));
        sz = clamp_size(r_size_z, POS_W'(MAX_Z));
        x  = fix_pos(r_pos_x, POS_W'(MAX_X));
        y  = fix_pos(r_pos_y, POS_W'(MAX_Y));
        z  = fix_pos(r_pos_z, POS_W'(MAX_Z));
        n_pos_x = x + POS_W'(1);
        n_pos_y = y;
        n_pos_z = z;
        if (x >= sx) begin
            n_pos_x = POS_W'(1);
            if (y >= sy) begin
                n_pos_y = POS_W'(1);
                n_pos_z = (z >= sz) ? POS_W'(1) : z + POS_W'(1);
            end else begin
                n_pos_y = y + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= POS_W'(1);
            r_pos_y <= POS_W'(1);
            r_pos_z <= POS_W'(1);
        end else if (vox_acc) begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_pos_z <= n_pos_z;
        end
    end

    // Per-voxel word capture.
    always_ff @(posedge i_clk) begin
        if (vox_acc) begin
            r_cx   <= x;
            r_cy   <= y;
            r_cz   <= z;
            r_emit <= (x >= POS_W'(2)) && (y >= POS_W'(2)) && (z >= POS_W'(2));
            r_last <= (x >= sx) && (y >= sy) && (z >= sz);
            r_fx   <= i_in_word.field_x;
            r_fy   <= i_in_word.field_y;
            r_fz   <= i_in_word.field_z;
            r_mx   <= i_in_word.material_x;
            r_my   <= i_in_word.material_y;
            r_mz   <= i_in_word.material_z;
        end
    end

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        case (r_state)
            S_IDLE:  if (vox_acc) n_state = S_WEIGH;
            S_WEIGH: n_state = S_DIFF;
            S_DIFF:  n_state = S_SUM;
            S_SUM: begin
                if (!r_emit) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign xm1 = r_cx - POS_W'(1);
    assign ym1 = r_cy - POS_W'(1);

    ycb_mat_table u_mat (
        .i_clk        (i_clk),
        .i_load_en    (load_acc),
        .i_load_index (i_in_word.load_index),
        .i_load_rmu_x (i_in_word.load_rmu_x),
        .i_load_rmu_y (i_in_word.load_rmu_y),
        .i_load_rmu_z (i_in_word.load_rmu_z),
        .i_weigh_en   (r_state == S_WEIGH),
        .i_field_x    (r_fx),
        .i_field_y    (r_fy),
        .i_field_z    (r_fz),
        .i_mat_x      (r_mx),
        .i_mat_y      (r_my),
        .i_mat_z      (r_mz),
        .o_w          (cur_w)
    );

    ycb_nbr_store u_store (
        .i_clk   (i_clk),
        .i_rd_en (r_state == S_WEIGH),
        .i_wr_en (r_state == S_DIFF),
        .i_x_idx (xm1[XI_W-1:0]),
        .i_y_idx (ym1[YI_W-1:0]),
        .i_wr    (cur_w),
        .o_prev  (nb_x),
        .o_row   (nb_y),
        .o_plane (nb_z)
    );

    ycb_curl u_curl (
        .i_clk    (i_clk),
        .i_en     (r_state == S_DIFF),
        .i_coef_x (r_coef_x),
        .i_coef_y (r_coef_y),
        .i_coef_z (r_coef_z),
        .i_cur    (cur_w),
        .i_nx     (nb_x),
        .i_ny     (nb_y),
        .i_nz     (nb_z),
        .o_curl_x (curl_x),
        .o_curl_y (curl_y),
        .o_curl_z (curl_z)
    );

    // Output word register.
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid   = 1'b1;
            n_out.curl_x  = curl_x;
            n_out.curl_y  = curl_y;
            n_out.curl_z  = curl_z;
            n_out.cell_x  = r_cx;
            n_out.cell_y  = r_cy;
            n_out.cell_z  = r_cz;
            n_out.last    = r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // A voxel reaches the finish step through the weigh and diff states after it is taken.
    a_vox_to_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vox_acc |-> ##3 (r_state == S_SUM))
        else $error("voxel did not reach finish step");

    // A new result word only comes from the finish step.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_SUM))
        else $error("result word appeared outside finish step");

    // Result coordinates are interior.
    a_out_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.cell_x >= POS_W'(2)) && (o_out_word.cell_y >= POS_W'(2))
                        && (o_out_word.cell_z >= POS_W'(2)))
        else $error("result for a boundary voxel");

    // A load word leaves the raster position alone.
    a_load_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_acc |=> $stable(r_pos_x) && $stable(r_pos_y) && $stable(r_pos_z))
        else $error("load word moved the position");

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the Yee curl-B stencil, with its own fixed-point predictor.
`timescale 1ns / 100ps

module tb;
    import ycb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEM_TARGET    = 850;
    localparam int SETTLE_CYCLES  = 8;

    // One weighted field triple as the predictor keeps it.
    typedef struct {
        longint x;
        longint y;
        longint z;
    } weighted_t;

    // One row of the directed stimulus table.
    typedef struct {
        t_in_word  word;
        bit        typed;
        t_out_word result;
    } stim_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_A_W-1:0] i_cfg_addr = '0;
    logic [COEF_W-1:0]  i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_in_word           i_in_word = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_word          o_out_word;

    yee_curl_b_stencil_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // Predictor state: registers, material tables, neighbor stores and position.
    logic [COEF_W-1:0] mdl_coef_x = '0, mdl_coef_y = '0, mdl_coef_z = '0;
    logic [POS_W-1:0]  mdl_size_x = 1, mdl_size_y = 1, mdl_size_z = 1;
    logic [RMU_W-1:0]  rmu_x [MATERIALS];
    logic [RMU_W-1:0]  rmu_y [MATERIALS];
    logic [RMU_W-1:0]  rmu_z [MATERIALS];
    weighted_t         prev_w;
    weighted_t         row_w [MAX_X];
    weighted_t         plane_w [MAX_X*MAX_Y];
    int                cur_x = 1, cur_y = 1, cur_z = 1;

    t_out_word curl_due_q [$];
    int        errors = 0;
    int        items_sent = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        quiet_cycles = 0;

    // Clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint weigh(logic signed [FIELD_W-1:0] f, logic [RMU_W-1:0] r);
        return (longint'(f) * longint'(r) + 32768) >>> 16;
    endfunction

    function automatic logic [FIELD_W-1:0] round_sat(longint t);
        longint v;
        v = (t + 32768) >>> 16;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[FIELD_W-1:0];
    endfunction

    function automatic int clamp_size(logic [POS_W-1:0] s, int lim);
        if (s == 0) return 1;
        return (s > lim) ? lim : int'(s);
    endfunction

    // Advance the predictor by one accepted word; queue the curl it yields, if any.
    function automatic void curl_stencil_step(t_in_word w, bit typed, t_out_word typed_res);
        int        sx, sy, sz, pidx;
        weighted_t cw, nx, ny, nz;
        longint    cx, cy, cz;
        t_out_word r;
        if (w.mode == MODE_LOAD) begin
            rmu_x[w.load_index] = w.load_rmu_x;
            rmu_y[w.load_index] = w.load_rmu_y;
            rmu_z[w.load_index] = w.load_rmu_z;
            return;
        end
        sx = clamp_size(mdl_size_x, MAX_X);
        sy = clamp_size(mdl_size_y, MAX_Y);
        sz = clamp_size(mdl_size_z, MAX_Z);
        cw.x = weigh(w.field_x, rmu_x[w.material_x]);
        cw.y = weigh(w.field_y, rmu_y[w.material_y]);
        cw.z = weigh(w.field_z, rmu_z[w.material_z]);
        pidx = (cur_y - 1) * MAX_X + (cur_x - 1);
        nx = prev_w;
        ny = row_w[cur_x-1];
        nz = plane_w[pidx];
        if (cur_x >= 2 && cur_y >= 2 && cur_z >= 2) begin
            cx = longint'(mdl_coef_x);
            cy = longint'(mdl_coef_y);
            cz = longint'(mdl_coef_z);
            r.curl_x = round_sat(cy * (cw.z - ny.z) - cz * (cw.y - nz.y));
            r.curl_y = round_sat(cz * (cw.x - nz.x) - cx * (cw.z - nx.z));
            r.curl_z = round_sat(cx * (cw.y - nx.y) - cy * (cw.x - ny.x));
            r.cell_x = cur_x[POS_W-1:0];
            r.cell_y = cur_y[POS_W-1:0];
            r.cell_z = cur_z[POS_W-1:0];
            r.last   = (cur_x >= sx && cur_y >= sy && cur_z >= sz);
            curl_due_q.push_back(typed ? typed_res : r);
        end
        prev_w = cw;
        row_w[cur_x-1] = cw;
        plane_w[pidx] = cw;
        // A coordinate at or past its size ends its axis.
        if (cur_x >= sx) begin
            cur_x = 1;
            if (cur_y >= sy) begin
                cur_y = 1;
                cur_z = (cur_z >= sz) ? 1 : cur_z + 1;
            end else begin
                cur_y++;
            end
        end else begin
            cur_x++;
        end
    endfunction

    // Receiver stall pattern.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare each delivered word with the oldest pending prediction.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (curl_due_q.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual %h",
                         $time, o_out_word);
                errors++;
            end else begin
                want = curl_due_q.pop_front();
                check_field("curl_x", want.curl_x, o_out_word.curl_x);
                check_field("curl_y", want.curl_y, o_out_word.curl_y);
                check_field("curl_z", want.curl_z, o_out_word.curl_z);
                check_field("cell_x", want.cell_x, o_out_word.cell_x);
                check_field("cell_y", want.cell_y, o_out_word.cell_y);
                check_field("cell_z", want.cell_z, o_out_word.cell_z);
                check_field("last", want.last, o_out_word.last);
            end
        end
    end

    // Watchdog on cycles where neither channel moves a word.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one word, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_word(t_in_word w, bit typed = 1'b0, t_out_word typed_res = '0);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        curl_stencil_step(w, typed, typed_res);
        items_sent++;
    endtask

    // Stop sending and wait until every predicted word has arrived.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (curl_due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [COEF_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_COEF_X: mdl_coef_x = val;
            CFG_COEF_Y: mdl_coef_y = val;
            CFG_COEF_Z: mdl_coef_z = val;
            CFG_SIZE_X: mdl_size_x = val[POS_W-1:0];
            CFG_SIZE_Y: mdl_size_y = val[POS_W-1:0];
            CFG_SIZE_Z: mdl_size_z = val[POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [COEF_W-1:0] cx, cy, cz, logic [POS_W-1:0] sx, sy, sz);
        write_reg(CFG_COEF_X, cx);
        write_reg(CFG_COEF_Y, cy);
        write_reg(CFG_COEF_Z, cz);
        write_reg(CFG_SIZE_X, COEF_W'(sx));
        write_reg(CFG_SIZE_Y, COEF_W'(sy));
        write_reg(CFG_SIZE_Z, COEF_W'(sz));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [FIELD_W-1:0] rand_field();
        case ($urandom_range(4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(255) - 128;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [RMU_W-1:0] rand_rmu();
        case ($urandom_range(3))
            0: return '1;
            1: return '0;
            default: return RMU_W'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(3))
            0: return '1;
            1: return '0;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // Random word; unused fields carry random values too.
    function automatic t_in_word rand_word(logic mode);
        t_in_word w;
        w = $bits(t_in_word)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        w.mode       = mode;
        w.field_x    = rand_field();
        w.field_y    = rand_field();
        w.field_z    = rand_field();
        w.load_rmu_x = rand_rmu();
        w.load_rmu_y = rand_rmu();
        w.load_rmu_z = rand_rmu();
        return w;
    endfunction

    // Stream voxels, with a few table loads mixed in, until the grid wraps.
    task automatic run_pass(int shrink_after, logic [POS_W-1:0] shrink_to);
        int n;
        n = 0;
        do begin
            if ($urandom_range(9) == 0) send_word(rand_word(MODE_LOAD));
            send_word(rand_word(MODE_VOXEL));
            n++;
            if (n == shrink_after) begin
                drain();
                write_reg(CFG_SIZE_X, COEF_W'(shrink_to));
                i_cfg_we <= 1'b0;
                @(posedge i_clk);
            end
        end while (!(cur_x == 1 && cur_y == 1 && cur_z == 1));
    endtask

    initial begin
        stim_row_t table_rows [$];
        stim_row_t row;
        int        ph;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fill every material row (extremes at both ends), then one
        // 2x2x2 pass with zero coefficients, so the only result is a zero curl.
        configure('0, '0, '0, 2, 2, 2);
        for (int i = 0; i < MATERIALS; i++) begin
            row = '{default: '0};
            row.word.mode       = MODE_LOAD;
            row.word.load_index = MAT_W'(i);
            row.word.load_rmu_x = (i == MATERIALS-1) ? '1 : RMU_W'(i * 20'h0_1111);
            row.word.load_rmu_y = (i == MATERIALS-1) ? '1 : RMU_W'(i * 20'h0_2222);
            row.word.load_rmu_z = (i == MATERIALS-1) ? '1 : RMU_W'(i * 20'h0_0F0F);
            table_rows.push_back(row);
        end
        for (int i = 0; i < 8; i++) begin
            row = '{default: '0};
            row.word.mode       = MODE_VOXEL;
            row.word.field_x    = i[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
            row.word.field_y    = i[1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            row.word.field_z    = i[2] ? 32'hFFFF_FFFF : 32'h0000_0000;
            row.word.material_x = i[0] ? MAT_W'(MATERIALS-1) : '0;
            row.word.material_y = MAT_W'(i * 2);
            row.word.material_z = MAT_W'(MATERIALS-1 - i);
            if (i == 7) begin
                row.typed  = 1'b1;
                row.result = '{curl_x: '0, curl_y: '0, curl_z: '0,
                               cell_x: 2, cell_y: 2, cell_z: 2, last: 1'b1};
            end
            table_rows.push_back(row);
        end
        foreach (table_rows[i]) begin
            send_word(table_rows[i].word, table_rows[i].typed, table_rows[i].result);
        end
        drain();

        // Random passes under rotating idle and stall patterns.
        ph = 0;
        while (items_sent < ITEM_TARGET) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 78; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 78; end
                default: begin send_idle_pct = 38; stall_pct = 38; end
            endcase
            case (ph)
                1: configure('1, '0, '1, 0, 3, 2);
                2: configure('1, '1, '1, 127, 2, 2);
                3: configure('1, '1, '0, 2, 2, 64);
                4: configure(rand_coef(), rand_coef(), rand_coef(), 4, 3, 3);
                5: configure('1, '1, '1, 2, 64, 2);
                default: configure(rand_coef(), rand_coef(), rand_coef(),
                                   POS_W'($urandom_range(5, 1)),
                                   POS_W'($urandom_range(5, 1)),
                                   POS_W'($urandom_range(5, 1)));
            endcase
            // Phase 4 narrows the x axis while a plane is under way.
            run_pass((ph == 4) ? 14 : -1, 2);
            drain();
            ph++;
        end

        send_idle_pct = 0;
        stall_pct = 0;
        drain();
        if (errors == 0 && curl_due_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/ycb_pkg.sv
rtl/core/ycb_mat_table.sv
rtl/core/ycb_nbr_store.sv
rtl/core/ycb_curl.sv
rtl/core/yee_curl_b_stencil_top.sv
verif/tb.sv
